// ===== src/smt_pkg.sv =====
// ============================================================================
// smt_pkg
// Shared command codes and controller/datapath interface types for the
// set membership table.
// ============================================================================
`default_nettype none

package smt_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch request, clear scan flags
        logic scan;     // read one entry, advance scan index
        logic update;   // write back, register result
    } smt_ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;  // current read is the last entry
    } smt_stat_t;

endpackage

`default_nettype wire

// ===== src/smt_ctrl.sv =====
// ============================================================================
// smt_ctrl
// Request sequencer: idle, entry scan, compare drain, write-back.
// ============================================================================
`default_nettype none

module smt_ctrl
    import smt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    output smt_ctrl_t      ctrl,
    input  wire smt_stat_t stat
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        ctrl.load   = 1'b0;
        ctrl.scan   = 1'b0;
        ctrl.update = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    ctrl.load  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                ctrl.scan = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                ctrl.update = 1'b1;
                state_next  = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// ===== src/smt_datapath.sv =====
// ============================================================================
// smt_datapath
// Entry store, valid bits, scan/compare pipeline, count and result registers.
// ============================================================================
`default_nettype none

module smt_datapath
    import smt_pkg::*;
#(
    parameter int unsigned CAPACITY      = 16,
    parameter int unsigned ELEMENT_WIDTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire smt_ctrl_t   ctrl,
    output smt_stat_t        stat,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] element,
    output logic             done,
    output logic             was_present,
    output logic             status,
    output logic [4:0]       element_count,
    output logic             is_empty
);

    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    logic [ELEMENT_WIDTH-1:0] mem [CAPACITY];

    logic [63:0]              elem_ext;
    logic [1:0]               cmd_reg;
    logic [ELEMENT_WIDTH-1:0] key_reg;
    logic [IDX_W-1:0]         rd_idx_reg;
    logic [ELEMENT_WIDTH-1:0] rd_data_reg;
    logic                     rd_vld_reg;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic                     cmp_en_reg;
    logic                     hit_reg;
    logic [IDX_W-1:0]         hit_idx_reg;
    logic                     free_reg;
    logic [IDX_W-1:0]         free_idx_reg;
    logic [CAPACITY-1:0]      valid_reg;
    logic [CNT_W-1:0]         held_count_reg;
    logic [CNT_W-1:0]         held_count_next;
    logic                     do_insert;
    logic                     do_remove;
    logic                     refused;
    logic [15:0]              count_ext;
    logic                     done_reg;
    logic                     was_present_reg;
    logic                     status_reg;
    logic [4:0]               element_count_reg;
    logic                     is_empty_reg;

    // only the low ELEMENT_WIDTH bits are stored and compared
    assign elem_ext = {32'b0, element};

    assign stat.scan_last = (rd_idx_reg == LAST_IDX);

    // ---- write-back decisions ----
    always_comb begin
        do_insert       = 1'b0;
        do_remove       = 1'b0;
        refused         = 1'b0;
        held_count_next = held_count_reg;
        if (cmd_reg == CMD_INSERT && !hit_reg) begin
            if (free_reg && (held_count_reg < CAPACITY)) begin
                do_insert       = 1'b1;
                held_count_next = held_count_reg + 1'b1;
            end
            else begin
                refused = 1'b1;
            end
        end
        else if (cmd_reg == CMD_REMOVE && hit_reg) begin
            do_remove = 1'b1;
            if (held_count_reg != '0) begin
                held_count_next = held_count_reg - 1'b1;
            end
        end
    end

    assign count_ext = 16'(held_count_next);

    // ---- entry store: one write, one registered read ----
    always_ff @(posedge clk) begin
        if (ctrl.update && do_insert) begin
            mem[free_idx_reg] <= key_reg;
        end
        if (ctrl.scan) begin
            rd_data_reg <= mem[rd_idx_reg];
        end
        if (ctrl.load) begin
            cmd_reg <= command;
            key_reg <= elem_ext[ELEMENT_WIDTH-1:0];
        end
        if (ctrl.scan) begin
            cmp_idx_reg <= rd_idx_reg;
        end
        if (ctrl.update) begin
            was_present_reg   <= hit_reg;
            status_reg        <= refused;
            element_count_reg <= count_ext[4:0];
            is_empty_reg      <= (held_count_next == '0);
        end
    end

    // ---- scan index, compare stage, flags, valid bits, count ----
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rd_idx_reg     <= '0;
            rd_vld_reg     <= 1'b0;
            cmp_en_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            free_reg       <= 1'b0;
            free_idx_reg   <= '0;
            valid_reg      <= '0;
            held_count_reg <= '0;
            done_reg       <= 1'b0;
        end
        else begin
            done_reg   <= ctrl.update;
            cmp_en_reg <= ctrl.scan;
            if (ctrl.load) begin
                rd_idx_reg <= '0;
                hit_reg    <= 1'b0;
                free_reg   <= 1'b0;
            end
            else begin
                if (ctrl.scan) begin
                    rd_vld_reg <= valid_reg[rd_idx_reg];
                    if (!stat.scan_last) begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                end
                if (cmp_en_reg) begin
                    if (rd_vld_reg && rd_data_reg == key_reg && !hit_reg) begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= cmp_idx_reg;
                    end
                    // lowest free entry wins
                    if (!rd_vld_reg && !free_reg) begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= cmp_idx_reg;
                    end
                end
            end
            if (ctrl.update) begin
                held_count_reg <= held_count_next;
                if (do_insert) begin
                    valid_reg[free_idx_reg] <= 1'b1;
                end
                if (do_remove) begin
                    valid_reg[hit_idx_reg] <= 1'b0;
                end
            end
        end
    end

    assign done          = done_reg;
    assign was_present   = was_present_reg;
    assign status        = status_reg;
    assign element_count = element_count_reg;
    assign is_empty      = is_empty_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= CAPACITY)
        else $error("held count above capacity");

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg == $countones(valid_reg))
        else $error("held count disagrees with valid bits");

    a_refused_not_present: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg |-> !was_present_reg)
        else $error("full status reported for a present element");
`endif

endmodule

`default_nettype wire

// ===== src/set_membership_table.sv =====
// ============================================================================
// set_membership_table
// Bounded set of distinct element values with insert, remove and query.
// ============================================================================
// Usage:
//   A request is taken at a rising edge with start high and busy low; command
//   and element are sampled there. command: insert, remove or query (the
//   unused code behaves as a query). Only the low ELEMENT_WIDTH bits of
//   element are stored and compared.
//   Each request yields one result, shown for exactly one cycle with done
//   high: was_present (before the request), status (1 = insert refused, the
//   store is full), element_count (after the request, low 5 bits) and
//   is_empty. The receiver cannot stall; results are never held back.
//   Sequence: the request scans all CAPACITY entries through a single
//   registered read port, one entry per cycle, then a drain state finishes
//   the last compare and a write-back state follows. done rises in the
//   cycle after write-back, and busy is already low in that cycle, so the
//   next request can be taken at the edge that ends it; no new request is
//   taken while one is still in progress.
//   Reset (rst_n low, asynchronous) empties the set by clearing every valid
//   bit and the count at once; stored values need no clearing.
// ============================================================================
`default_nettype none

module set_membership_table
    import smt_pkg::*;
#(
    parameter int unsigned CAPACITY      = 16,
    parameter int unsigned ELEMENT_WIDTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] element,
    output logic             done,
    output logic             was_present,
    output logic             status,
    output logic [4:0]       element_count,
    output logic             is_empty
);

    smt_ctrl_t ctrl;   // sequencer commands
    smt_stat_t stat;   // datapath status

    // state machine: idle -> scan (CAPACITY reads) -> drain -> write-back
    smt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctrl  (ctrl),
        .stat  (stat)
    );

    // entry store, compare pipeline and result registers
    smt_datapath #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .command       (command),
        .element       (element),
        .done          (done),
        .was_present   (was_present),
        .status        (status),
        .element_count (element_count),
        .is_empty      (is_empty)
    );

endmodule

`default_nettype wire
